// File: rtl/csvf_pkg.sv
// ----------------------------------------------------------------------------
// csvf_pkg: shared types and arithmetic for the cascaded svf filter
// Request, result, link and config types, the section state codes, and the
// rounding and saturation helpers used by every filter section.
// ----------------------------------------------------------------------------
`default_nettype none

package csvf_pkg;

	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 27;
	localparam int ACC_W    = 32;
	localparam int R2G_W    = 29;
	localparam int PROD_W   = 61;
	localparam int RND_W    = 41;
	localparam int SUM_W    = 44;
	localparam int FRAC_W   = 20;
	localparam int CFG_W    = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_STAGES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TYPE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_HP_MIX   = 2'd2;

	localparam logic [1:0] KIND_GAIN    = 2'd0;
	localparam logic [1:0] KIND_DAMPING = 2'd1;
	localparam logic [1:0] KIND_NORM    = 2'd2;

	localparam logic [1:0] RESP_LP   = 2'd0;
	localparam logic [1:0] RESP_BP   = 2'd1;
	localparam logic [1:0] RESP_HP   = 2'd2;
	localparam logic [1:0] RESP_LPHP = 2'd3;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_COEF   = 1'b1;

	typedef struct packed {
		logic                       command;
		logic                       channel;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [2:0]                 coef_stage;
		logic [1:0]                 coef_kind;
		logic [COEF_W-1:0]          coef_value;
	} csvf_req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       saturated;
	} csvf_res_t;

	// request travelling down the chain plus the running clip flag
	typedef struct packed {
		csvf_req_t req;
		logic      sat;
	} csvf_link_t;

	typedef struct packed {
		logic [3:0] active_stages;
		logic [1:0] response_type;
		logic       half_highpass_mix;
	} csvf_cfg_t;

	typedef struct packed {
		logic                    sat;
		logic signed [ACC_W-1:0] val;
	} csvf_clip_acc_t;

	typedef struct packed {
		logic                       sat;
		logic signed [SAMPLE_W-1:0] val;
	} csvf_clip_out_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_MUL_FB,
		CS_RND_FB,
		CS_T,
		CS_MUL_H,
		CS_HP,
		CS_MUL_GHP,
		CS_RND_GHP,
		CS_BP,
		CS_MUL_GBP,
		CS_RND_GBP,
		CS_LP,
		CS_S2,
		CS_HOLD
	} csvf_state_t;

	// Q20 product back to Q.23 step: nearest, ties away from zero
	function automatic logic signed [RND_W-1:0] round_q20(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] b;
		b = p + (p[PROD_W-1] ? PROD_W'((1 << (FRAC_W - 1)) - 1) : PROD_W'(1 << (FRAC_W - 1)));
		return b[PROD_W-1:FRAC_W];
	endfunction

	function automatic csvf_clip_acc_t clip_acc(input logic signed [SUM_W-1:0] v);
		csvf_clip_acc_t r;
		r.sat = (v[SUM_W-1:ACC_W-1] != {(SUM_W - ACC_W + 1){v[SUM_W-1]}});
		if (r.sat) begin
			r.val = v[SUM_W-1] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
		end else begin
			r.val = v[ACC_W-1:0];
		end
		return r;
	endfunction

	function automatic csvf_clip_out_t clip_out(input logic signed [SUM_W-1:0] v);
		csvf_clip_out_t r;
		r.sat = (v[SUM_W-1:SAMPLE_W-1] != {(SUM_W - SAMPLE_W + 1){v[SUM_W-1]}});
		if (r.sat) begin
			r.val = v[SUM_W-1] ? {1'b1, {(SAMPLE_W - 1){1'b0}}} : {1'b0, {(SAMPLE_W - 1){1'b1}}};
		end else begin
			r.val = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/csvf_cell.sv
// ----------------------------------------------------------------------------
// csvf_cell: one filter section of the cascade
// Holds its own g, R, h coefficients and both integrators for every channel.
// A sample runs through twelve steps on one shared multiplier; coefficient
// writes and sections beyond the active count pass straight through.
// ----------------------------------------------------------------------------
`default_nettype none

module csvf_cell
	import csvf_pkg::*;
#(
	parameter int IDX      = 0,
	parameter int CHANNELS = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire csvf_cfg_t  cfg,
	input  wire logic       up_valid,
	output logic            up_ready,
	input  wire csvf_link_t up_item,
	output logic            dn_valid,
	input  wire logic       dn_ready,
	output csvf_link_t      dn_item
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [4:0] IDX5 = 5'(IDX);

	csvf_state_t state_q, state_d;

	logic [COEF_W-1:0]       gain_q, damp_q, norm_q;
	logic signed [ACC_W-1:0] s1_mem_q [CHANNELS];
	logic signed [ACC_W-1:0] s2_mem_q [CHANNELS];

	csvf_link_t              item_q;
	logic [CH_W-1:0]         ch_q;
	logic signed [ACC_W-1:0] s1_q, s2_q, t_q, hp_q, bp_q, lp_q, s1n_q;
	logic [R2G_W-1:0]        r2g_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [RND_W-1:0] rnd_q;

	logic                    accept;
	logic                    active;
	logic [CH_W-1:0]         ch_in;
	logic signed [ACC_W-1:0] mul_a;
	logic [R2G_W-1:0]        mul_b;
	logic signed [PROD_W-1:0] prod_c;
	csvf_clip_acc_t          t_c, hp_c, bp_c, s1n_c, lp_c, s2n_c;
	csvf_clip_out_t          y_c;
	logic signed [SUM_W-1:0] y_sum;

	assign accept = (state_q == CS_IDLE) && up_valid;
	assign active = {1'b0, cfg.active_stages} > IDX5;
	assign ch_in  = (CHANNELS == 1) ? '0 : CH_W'(up_item.req.channel);
	assign prod_c = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (up_valid) begin
					if (up_item.req.command == CMD_COEF || !active) begin
						state_d = CS_HOLD;
					end else begin
						state_d = CS_MUL_FB;
					end
				end
			end
			CS_MUL_FB:  state_d = CS_RND_FB;
			CS_RND_FB:  state_d = CS_T;
			CS_T:       state_d = CS_MUL_H;
			CS_MUL_H:   state_d = CS_HP;
			CS_HP:      state_d = CS_MUL_GHP;
			CS_MUL_GHP: state_d = CS_RND_GHP;
			CS_RND_GHP: state_d = CS_BP;
			CS_BP:      state_d = CS_MUL_GBP;
			CS_MUL_GBP: state_d = CS_RND_GBP;
			CS_RND_GBP: state_d = CS_LP;
			CS_LP:      state_d = CS_S2;
			CS_S2:      state_d = CS_HOLD;
			CS_HOLD: begin
				if (dn_ready) begin
					state_d = CS_IDLE;
				end
			end
			default:    state_d = CS_IDLE;
		endcase
	end

	// outputs and multiplier operands
	always_comb begin
		up_ready = (state_q == CS_IDLE);
		dn_valid = (state_q == CS_HOLD);
		dn_item  = item_q;
		case (state_q)
			CS_MUL_FB: begin
				mul_a = s1_q;
				mul_b = r2g_q;
			end
			CS_MUL_H: begin
				mul_a = t_q;
				mul_b = R2G_W'(norm_q);
			end
			CS_MUL_GHP: begin
				mul_a = hp_q;
				mul_b = R2G_W'(gain_q);
			end
			default: begin
				mul_a = bp_q;
				mul_b = R2G_W'(gain_q);
			end
		endcase
	end

	// section arithmetic; rnd_q holds g*hp until the gbp product lands
	always_comb begin
		t_c   = clip_acc(SUM_W'(item_q.req.sample_in) - SUM_W'(rnd_q) - SUM_W'(s2_q));
		hp_c  = clip_acc(SUM_W'(round_q20(prod_q)));
		bp_c  = clip_acc(SUM_W'(rnd_q) + SUM_W'(s1_q));
		s1n_c = clip_acc(SUM_W'(rnd_q) + SUM_W'(bp_q));
		lp_c  = clip_acc(SUM_W'(rnd_q) + SUM_W'(s2_q));
		s2n_c = clip_acc(SUM_W'(rnd_q) + SUM_W'(lp_q));
		if (cfg.half_highpass_mix) begin
			y_sum = SUM_W'(lp_q) + SUM_W'(hp_q >>> 1);
		end else begin
			case (cfg.response_type)
				RESP_LP: y_sum = SUM_W'(lp_q);
				RESP_BP: y_sum = SUM_W'(bp_q);
				RESP_HP: y_sum = SUM_W'(hp_q);
				default: y_sum = SUM_W'(lp_q) + SUM_W'(hp_q);
			endcase
		end
		y_c = clip_out(y_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			gain_q  <= '0;
			damp_q  <= '0;
			norm_q  <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				s1_mem_q[c] <= '0;
				s2_mem_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept && up_item.req.command == CMD_COEF &&
			    {2'b00, up_item.req.coef_stage} == IDX5) begin
				case (up_item.req.coef_kind)
					KIND_GAIN:    gain_q <= up_item.req.coef_value;
					KIND_DAMPING: damp_q <= up_item.req.coef_value;
					KIND_NORM:    norm_q <= up_item.req.coef_value;
					default:      ;
				endcase
			end
			if (state_q == CS_S2) begin
				s1_mem_q[ch_q] <= s1n_q;
				s2_mem_q[ch_q] <= s2n_c.val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= up_item;
			ch_q   <= ch_in;
			s1_q   <= s1_mem_q[ch_in];
			s2_q   <= s2_mem_q[ch_in];
			r2g_q  <= R2G_W'({damp_q, 1'b0}) + R2G_W'(gain_q);
		end
		case (state_q)
			CS_MUL_FB, CS_MUL_H, CS_MUL_GHP: prod_q <= prod_c;
			CS_RND_FB, CS_RND_GHP, CS_RND_GBP: rnd_q <= round_q20(prod_q);
			CS_T: begin
				t_q        <= t_c.val;
				item_q.sat <= item_q.sat | t_c.sat;
			end
			CS_HP: begin
				hp_q       <= hp_c.val;
				item_q.sat <= item_q.sat | hp_c.sat;
			end
			CS_BP: begin
				bp_q       <= bp_c.val;
				item_q.sat <= item_q.sat | bp_c.sat;
			end
			CS_MUL_GBP: begin
				prod_q     <= prod_c;
				s1n_q      <= s1n_c.val;
				item_q.sat <= item_q.sat | s1n_c.sat;
			end
			CS_LP: begin
				lp_q       <= lp_c.val;
				item_q.sat <= item_q.sat | lp_c.sat;
			end
			CS_S2: begin
				item_q.req.sample_in <= y_c.val;
				item_q.sat           <= item_q.sat | s2n_c.sat | y_c.sat;
			end
			default: ;
		endcase
	end

	a_idle_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_IDLE && !up_valid) |=> (state_q == CS_IDLE))
		else $error("section left idle without a request");

	a_coef_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_IDLE && up_valid && up_item.req.command == CMD_COEF)
		|=> (state_q == CS_HOLD))
		else $error("coefficient write entered the datapath");

	a_update_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_S2) |=> (state_q == CS_HOLD))
		else $error("integrator update not followed by hand-off");

	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_HOLD && !dn_ready) |=> (state_q == CS_HOLD && $stable(item_q)))
		else $error("held section output changed");

endmodule

`default_nettype wire

// File: rtl/cascaded_svf_filter_core.sv
// ----------------------------------------------------------------------------
// cascaded_svf_filter_core: multichannel cascade of tpt state-variable filters
// Chain of filter sections followed by a result register.
// ----------------------------------------------------------------------------
// Requests enter a chain of MAX_STAGES sections and move down it in order;
// coefficient writes travel the same chain, so they take effect exactly
// between the samples around them. An active section runs a sample through
// twelve steps around its one multiplier, then holds it for hand-on and
// returns to idle; an inactive section or a coefficient write goes straight
// to hold. Sections work on different samples at once, so a new sample is
// taken once the first section is back in idle, and a held section waits
// until the next one takes its item. The result register follows the chain.
`default_nettype none

module cascaded_svf_filter_core
	import csvf_pkg::*;
#(
	parameter int MAX_STAGES = 8,
	parameter int CHANNELS   = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire csvf_req_t            req,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output csvf_res_t                 res
);

	csvf_cfg_t  cfg_q;
	csvf_link_t link [MAX_STAGES+1];
	logic       link_valid [MAX_STAGES+1];
	logic       link_ready [MAX_STAGES+1];
	logic       res_valid_q;
	csvf_res_t  res_q;
	logic       last_is_coef;
	logic       res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_stages     <= 4'd1;
			cfg_q.response_type     <= RESP_LP;
			cfg_q.half_highpass_mix <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE_STAGES: cfg_q.active_stages     <= cfg_data;
				CFG_RESPONSE_TYPE: cfg_q.response_type     <= cfg_data[1:0];
				CFG_HALF_HP_MIX:   cfg_q.half_highpass_mix <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	assign link_valid[0] = req_valid;
	assign link[0].req   = req;
	assign link[0].sat   = 1'b0;
	assign req_stall     = !link_ready[0];

	for (genvar i = 0; i < MAX_STAGES; i++) begin : g_sec
		csvf_cell #(
			.IDX      (i),
			.CHANNELS (CHANNELS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg_q),
			.up_valid (link_valid[i]),
			.up_ready (link_ready[i]),
			.up_item  (link[i]),
			.dn_valid (link_valid[i+1]),
			.dn_ready (link_ready[i+1]),
			.dn_item  (link[i+1])
		);
	end

	// coefficient writes end at the chain tail without a result
	assign last_is_coef = (link[MAX_STAGES].req.command == CMD_COEF);
	assign link_ready[MAX_STAGES] = last_is_coef || !res_valid_q || !res_stall;
	assign res_load = link_valid[MAX_STAGES] && !last_is_coef && link_ready[MAX_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.sample_out <= link[MAX_STAGES].req.sample_in;
			res_q.saturated  <= link[MAX_STAGES].sat;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire
